// ===== src/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Types and constants for the ARP responder with its address cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

  // operation codes
  localparam logic [1:0] OPER_MESSAGE = 2'd0;
  localparam logic [1:0] OPER_LOOKUP  = 2'd1;
  localparam logic [1:0] OPER_REQUEST = 2'd2;

  // result status codes
  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_REPLY   = 3'd1;
  localparam logic [2:0] ST_CACHED  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_HIT     = 3'd4;
  localparam logic [2:0] ST_MISS    = 3'd5;
  localparam logic [2:0] ST_REQUEST = 3'd6;

  // header values, compared in stored (byte-swapped) order
  localparam logic [15:0] HW_ETHERNET = 16'h0100;
  localparam logic [15:0] PROTO_IPV4  = 16'h0008;
  localparam logic [15:0] ARP_REQUEST = 16'h0100;
  localparam logic [15:0] ARP_REPLY   = 16'h0200;
  localparam logic [7:0]  HW_LEN      = 8'd6;
  localparam logic [7:0]  PROTO_LEN   = 8'd4;
  localparam logic [10:0] MSG_BYTES   = 11'd28;
  localparam logic [47:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;

  // register addresses (bit 3 of paddr selects the register)
  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [10:0] payload_length;
    logic [15:0] hardware_type;
    logic [15:0] protocol_type;
    logic [7:0]  hw_addr_len;
    logic [7:0]  proto_addr_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } arpc_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        send_frame;
    logic [15:0] out_opcode;
    logic [47:0] out_sender_mac;
    logic [31:0] out_sender_ip;
    logic [47:0] out_target_mac;
    logic [31:0] out_target_ip;
    logic [47:0] lookup_mac;
  } arpc_result_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } arpc_entry_t;

endpackage

// ===== src/arpc_chan_if.sv =====
// ----------------------------------------------------------------------------
// arpc_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface arpc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/arpc_ram.sv =====
// ----------------------------------------------------------------------------
// arpc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/arp_responder_with_cache.sv =====
// ----------------------------------------------------------------------------
// arp_responder_with_cache
// ARP responder: checks received messages, builds replies and requests, and
// keeps an append-only IP-to-MAC cache in one RAM that lookups scan in order.
// Flow: a received message, a request build and an unused operation go from
//   the input register through S_DONE to the output register; a lookup first
//   scans in S_SCAN, one cached entry per cycle through the single RAM
//   read port, until a hit or the last cached entry, then goes to S_DONE.
// Throughput: one item at a time; the next input is taken once the result is
//   in the output register, which may still wait on the sink.
// Reset: control state, own_ip, own_mac and the entry count clear at once;
//   cache contents are undefined and are never read before being written.
// ----------------------------------------------------------------------------
module arp_responder_with_cache
  import arpc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // channels
  arpc_chan_if.sink   in_ch,
  arpc_chan_if.source out_ch
);

  localparam int CW = $clog2(CACHE_ENTRIES + 1);
  localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [CW-1:0] ENTRIES = CW'(CACHE_ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state;
  logic [31:0]   own_ip;
  logic [47:0]   own_mac;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] issue_idx;
  logic          cmp_valid;
  logic          look_hit;
  logic [47:0]   look_mac;
  arpc_item_t    item;
  logic          out_valid;
  arpc_result_t  out_data;

  arpc_entry_t   rd_entry;
  arpc_entry_t   wr_entry;
  logic          ram_we;
  logic          issue;
  logic          hit_now;
  logic          msg_ok;
  logic          cache_full;
  logic          can_load;
  arpc_result_t  result;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3])
        REG_OWN_IP:  own_ip  <= pwdata[31:0];
        REG_OWN_MAC: own_mac <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_OWN_IP:  prdata = {32'd0, own_ip};
      REG_OWN_MAC: prdata = {16'd0, own_mac};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- cache
  arpc_ram #(
    .WIDTH ($bits(arpc_entry_t)),
    .DEPTH (CACHE_ENTRIES)
  ) u_cache (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count[AW-1:0]),
    .wdata (wr_entry),
    .raddr (issue_idx[AW-1:0]),
    .rdata (rd_entry)
  );

  assign wr_entry.ip  = item.sender_ip;
  assign wr_entry.mac = item.sender_mac;

  assign issue   = (state == S_SCAN) && (issue_idx < entry_count);
  assign hit_now = cmp_valid && (rd_entry.ip == item.query_ip);

  // ---------------------------------------------------------------- result
  assign msg_ok = (item.payload_length >= MSG_BYTES) &&
                  (item.hardware_type == HW_ETHERNET) &&
                  (item.protocol_type == PROTO_IPV4) &&
                  (item.hw_addr_len == HW_LEN) &&
                  (item.proto_addr_len == PROTO_LEN) &&
                  (item.target_ip == own_ip);
  assign cache_full = (entry_count >= ENTRIES);
  assign can_load   = !out_valid || out_ch.ready;

  always_comb begin
    result = '0;
    ram_we = 1'b0;
    case (item.operation)
      OPER_MESSAGE: begin
        if (msg_ok && item.opcode == ARP_REQUEST) begin
          result.status         = ST_REPLY;
          result.send_frame     = 1'b1;
          result.out_opcode     = ARP_REPLY;
          result.out_sender_mac = own_mac;
          result.out_sender_ip  = own_ip;
          result.out_target_mac = item.sender_mac;
          result.out_target_ip  = item.sender_ip;
        end else if (msg_ok && item.opcode == ARP_REPLY) begin
          if (cache_full) begin
            result.status = ST_FULL;
          end else begin
            result.status = ST_CACHED;
            ram_we        = (state == S_DONE) && can_load;
          end
        end
      end
      OPER_LOOKUP: begin
        result.status     = look_hit ? ST_HIT : ST_MISS;
        result.lookup_mac = look_hit ? look_mac : MAC_ALL_ONES;
      end
      OPER_REQUEST: begin
        result.status         = ST_REQUEST;
        result.send_frame     = 1'b1;
        result.out_opcode     = ARP_REQUEST;
        result.out_sender_mac = own_mac;
        result.out_sender_ip  = own_ip;
        result.out_target_mac = MAC_ALL_ONES;
        result.out_target_ip  = item.query_ip;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control
  assign in_ch.ready  = (state == S_IDLE) && !rst;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item <= in_ch.data;
    end
    if (state == S_DONE && can_load) begin
      out_data <= result;
    end
    if (state == S_SCAN && hit_now) begin
      look_mac <= rd_entry.mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      issue_idx   <= '0;
      cmp_valid   <= 1'b0;
      look_hit    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (state == S_DONE && can_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          issue_idx <= '0;
          cmp_valid <= 1'b0;
          if (in_ch.valid) begin
            state <= (in_ch.data.operation == OPER_LOOKUP) ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          // read issued, then compared in the next cycle once rd_entry is registered
          if (hit_now) begin
            look_hit  <= 1'b1;
            cmp_valid <= 1'b0;
            state     <= S_DONE;
          end else if (!issue && !cmp_valid) begin
            look_hit <= 1'b0;
            state    <= S_DONE;
          end else begin
            cmp_valid <= issue;
            if (issue) begin
              issue_idx <= issue_idx + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (can_load) begin
            state <= S_IDLE;
            if (ram_we) begin
              entry_count <= entry_count + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= ENTRIES)
    else $error("entry count beyond cache depth");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !ram_we)
    else $error("cache written during a lookup scan");

  a_cached_counts: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && can_load && result.status == ST_CACHED)
      |=> entry_count == $past(entry_count) + 1'b1)
    else $error("cached reply did not advance entry count");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (state == S_SCAN) && (issue_idx <= entry_count))
    else $error("compare outside a scan");

endmodule
